[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the speed controller RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PSPC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PSPC_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pspc_pkg.sv]
// ---------------------------------------------------------------------------
// PWM speed controller package
// Register indexes, reset values and the structs passed between modules.
// ---------------------------------------------------------------------------
package pspc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = 36;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_COUNT       = 3'd0,
        CFG_PWM_PERIOD         = 3'd1,
        CFG_PERIODS_PER_WINDOW = 3'd2,
        CFG_GAIN_P             = 3'd3,
        CFG_GAIN_D             = 3'd4
    } pspc_cfg_idx_t;

    localparam logic [9:0]  RST_TARGET_COUNT       = 10'd1;
    localparam logic [15:0] RST_PWM_PERIOD         = 16'd10000;
    localparam logic [7:0]  RST_PERIODS_PER_WINDOW = 8'd3;
    localparam logic [15:0] RST_GAIN_P             = 16'd1536;
    localparam logic [15:0] RST_GAIN_D             = 16'd205;

    localparam logic [15:0] MIN_PERIOD = 16'd2;
    localparam logic [15:0] SPEED_MAX  = 16'hFFFF;

    // Configuration as seen by the datapath, with the short-period and
    // zero-window cases already folded in.
    typedef struct packed {
        logic [9:0]  target;
        logic [15:0] period;
        logic [7:0]  need;
        logic [15:0] gain_p;
        logic [15:0] gain_d;
    } pspc_cfg_t;

    // Precomputed controller terms.
    typedef struct packed {
        logic [16:0]        k_sum;
        logic [26:0]        t_term;
        logic [32:0]        p_term;
        logic signed [33:0] d_term;
    } pspc_prod_t;

    // Core state fed to the multipliers.
    typedef struct packed {
        logic [15:0]        speed;
        logic signed [16:0] prev_err;
    } pspc_fb_t;

    // One result item.
    typedef struct packed {
        logic        window_done;
        logic [15:0] duty_ticks;
        logic [15:0] speed_count;
        logic        pwm_out;
    } pspc_res_t;

    typedef logic signed [SUM_W-1:0] pspc_sum_t;

endpackage

[hdl/pspc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Configuration registers
// Write-only register file with the effective period and window length.
// ---------------------------------------------------------------------------
module pspc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pspc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pspc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pspc_pkg::pspc_cfg_t              cfg
);

    logic [9:0]  target_reg;
    logic [15:0] period_reg;
    logic [7:0]  ppw_reg;
    logic [15:0] gain_p_reg;
    logic [15:0] gain_d_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= pspc_pkg::RST_TARGET_COUNT;
            period_reg <= pspc_pkg::RST_PWM_PERIOD;
            ppw_reg    <= pspc_pkg::RST_PERIODS_PER_WINDOW;
            gain_p_reg <= pspc_pkg::RST_GAIN_P;
            gain_d_reg <= pspc_pkg::RST_GAIN_D;
        end else if (cfg_valid && cfg_ready) begin
            unique case (pspc_pkg::pspc_cfg_idx_t'(cfg_index))
                pspc_pkg::CFG_TARGET_COUNT:       target_reg <= cfg_data[9:0];
                pspc_pkg::CFG_PWM_PERIOD:         period_reg <= cfg_data;
                pspc_pkg::CFG_PERIODS_PER_WINDOW: ppw_reg    <= cfg_data[7:0];
                pspc_pkg::CFG_GAIN_P:             gain_p_reg <= cfg_data;
                pspc_pkg::CFG_GAIN_D:             gain_d_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.target = target_reg;
        cfg.period = (period_reg < pspc_pkg::MIN_PERIOD) ? pspc_pkg::MIN_PERIOD : period_reg;
        cfg.need   = (ppw_reg == 8'd0) ? 8'd1 : ppw_reg;
        cfg.gain_p = gain_p_reg;
        cfg.gain_d = gain_d_reg;
    end

endmodule

[hdl/pspc_gain_mult.sv]
// ---------------------------------------------------------------------------
// Controller product terms
// Registers the gain products so the tick loop only adds and compares.
// ---------------------------------------------------------------------------
module pspc_gain_mult (
    input  logic                 aclk,
    input  pspc_pkg::pspc_cfg_t  cfg,
    input  pspc_pkg::pspc_fb_t   fb,
    output pspc_pkg::pspc_prod_t prod
);

    // The increment is rewritten as (Kp+Kd)*target - (Kp+Kd)*speed - Kd*prev_err.
    logic [16:0]        k_sum;
    logic [26:0]        t_term_reg;
    logic [32:0]        p_term_reg;
    logic signed [33:0] d_term_reg;

    assign k_sum = {1'b0, cfg.gain_p} + {1'b0, cfg.gain_d};

    always_ff @(posedge aclk) begin
        t_term_reg <= {10'd0, k_sum} * {17'd0, cfg.target};
        p_term_reg <= {16'd0, k_sum} * {17'd0, fb.speed};
        d_term_reg <= $signed({18'd0, cfg.gain_d}) * 34'(fb.prev_err);
    end

    always_comb begin
        prod.k_sum  = k_sum;
        prod.t_term = t_term_reg;
        prod.p_term = p_term_reg;
        prod.d_term = d_term_reg;
    end

endmodule

[hdl/pspc_tick_core.sv]
// ---------------------------------------------------------------------------
// Tick core
// PWM phase sequencing, pulse tally and the incremental duty update.
// ---------------------------------------------------------------------------
module pspc_tick_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick_en,
    input  logic                 pulse,
    input  pspc_pkg::pspc_cfg_t  cfg,
    input  pspc_pkg::pspc_prod_t prod,
    output pspc_pkg::pspc_fb_t   fb,
    output pspc_pkg::pspc_res_t  res
);

    localparam int SAT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [15:0]            phase_reg,    phase_next;
    logic                   high_reg,     high_next;
    logic [7:0]             periods_reg,  periods_next;
    logic [COUNT_WIDTH-1:0] tally_reg,    tally_next;
    logic [15:0]            latched_reg,  latched_next;
    logic [15:0]            duty_reg,     duty_next;
    logic signed [16:0]     prev_err_reg, prev_err_next;
    logic                   stepped_reg,  stepped_next;

    logic [SAT_W-1:0]       tally_wide;
    logic [15:0]            speed_sat;
    logic signed [16:0]     err;
    logic [15:0]            low_len;
    logic [15:0]            len1;
    logic                   end1;
    logic                   fall;
    logic [7:0]             pd_inc;
    logic                   win;
    pspc_pkg::pspc_sum_t    sum_full;
    logic                   sum_pos;
    logic                   at_period;
    logic [15:0]            duty_new;
    logic                   tally_room;

    // Saturated view of the running tally, the speed a window close would latch.
    assign tally_wide = SAT_W'(tally_reg);
    assign speed_sat  = (tally_wide > SAT_W'(pspc_pkg::SPEED_MAX)) ?
                        pspc_pkg::SPEED_MAX : tally_wide[15:0];
    assign err        = $signed({7'd0, cfg.target}) - $signed({1'b0, speed_sat});
    assign tally_room = (tally_reg != {COUNT_WIDTH{1'b1}});

    always_comb begin
        // The registered speed product lags the tally by one increment at most.
        sum_full = pspc_pkg::pspc_sum_t'({duty_reg, 8'h00})
                 + pspc_pkg::pspc_sum_t'(prod.t_term)
                 - pspc_pkg::pspc_sum_t'(prod.d_term)
                 - pspc_pkg::pspc_sum_t'(prod.p_term)
                 - pspc_pkg::pspc_sum_t'(stepped_reg ? prod.k_sum : 17'd0);
        sum_pos   = !sum_full[pspc_pkg::SUM_W-1] && (sum_full[pspc_pkg::SUM_W-2:8] != '0);
        at_period = sum_pos &&
                    (sum_full[pspc_pkg::SUM_W-2:8] >= (pspc_pkg::SUM_W-9)'(cfg.period));
        if (!sum_pos) begin
            duty_new = 16'd1;
        end else if (at_period) begin
            duty_new = cfg.period;
        end else begin
            duty_new = sum_full[23:8];
        end
    end

    always_comb begin
        low_len = (duty_reg >= cfg.period) ? 16'd0 : cfg.period - duty_reg;
        len1    = high_reg ? duty_reg : low_len;
        end1    = (phase_reg >= len1);
        // A low phase starts on a high-phase end, or right after an empty high phase.
        fall    = end1 && (high_reg || (duty_reg == 16'd0));
        pd_inc  = periods_reg + 8'd1;
        win     = tick_en && fall && (pd_inc >= cfg.need);

        duty_next     = win ? duty_new : duty_reg;
        latched_next  = win ? speed_sat : latched_reg;
        prev_err_next = win ? err : prev_err_reg;

        if (!end1) begin
            high_next = high_reg;
        end else if (high_reg) begin
            // An empty low phase is skipped straight back to high.
            high_next = win ? at_period : (duty_reg >= cfg.period);
        end else begin
            high_next = (duty_reg != 16'd0);
        end

        if (end1) begin
            phase_next = 16'd1;
        end else if (phase_reg != 16'hFFFF) begin
            phase_next = phase_reg + 16'd1;
        end else begin
            phase_next = phase_reg;
        end

        if (!fall) begin
            periods_next = periods_reg;
        end else if (win) begin
            periods_next = 8'd0;
        end else begin
            periods_next = pd_inc;
        end

        if (win) begin
            tally_next = COUNT_WIDTH'(pulse);
        end else if (pulse && tally_room) begin
            tally_next = tally_reg + COUNT_WIDTH'(1);
        end else begin
            tally_next = tally_reg;
        end

        stepped_next = tick_en && !win && pulse && tally_room &&
                       (tally_wide < SAT_W'(pspc_pkg::SPEED_MAX));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 16'd0;
            high_reg     <= 1'b1;
            periods_reg  <= 8'd0;
            tally_reg    <= '0;
            latched_reg  <= 16'd0;
            duty_reg     <= 16'd0;
            prev_err_reg <= 17'sd0;
            stepped_reg  <= 1'b0;
        end else begin
            stepped_reg <= stepped_next;
            if (tick_en) begin
                phase_reg    <= phase_next;
                high_reg     <= high_next;
                periods_reg  <= periods_next;
                tally_reg    <= tally_next;
                latched_reg  <= latched_next;
                duty_reg     <= duty_next;
                prev_err_reg <= prev_err_next;
            end
        end
    end

    always_comb begin
        fb.speed    = speed_sat;
        fb.prev_err = prev_err_reg;

        res.pwm_out     = high_next;
        res.speed_count = latched_next;
        res.duty_ticks  = duty_next;
        res.window_done = win;
    end

endmodule

[hdl/pwm_speed_pi_controller.sv]
// ---------------------------------------------------------------------------
// PWM speed controller, top level
// Tick-driven PWM generator with windowed encoder speed and PI duty update.
// ---------------------------------------------------------------------------
// Path: an accepted tick waits in the input register, steps the tick core once the
// result register has room, and is then held in the result register for the sink.
// Throughput: one item per clock cycle while the sink keeps taking results.
// Reset: synchronous, active low; clears phase, tally and duty, loads register defaults.
// A configuration write takes effect for items accepted from the next cycle on.
`include "assert_macros.svh"

module pwm_speed_pi_controller #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Tick input: [0] encoder_pulse, [7:1] zero.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,

    // Result: [0] pwm_out, [16:1] speed_count, [32:17] duty_ticks,
    // [33] window_done, [39:34] zero.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [39:0]                      m_tdata,

    // Register write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pspc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pspc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pspc_pkg::pspc_cfg_t  cfg;
    pspc_pkg::pspc_prod_t prod;
    pspc_pkg::pspc_fb_t   fb;
    pspc_pkg::pspc_res_t  core_res;

    // Input register: holds one tick until the core can take it.
    logic                 in_valid_reg, in_valid_next;
    logic                 in_pulse_reg;

    // Result register: holds one finished item until the sink takes it.
    logic                 out_valid_reg, out_valid_next;
    pspc_pkg::pspc_res_t  out_res_reg;

    logic                 advance;

    // The core steps whenever a tick is waiting and the result register has room,
    // including the cycle in which the sink empties it.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pulse_reg <= s_tdata[0];
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    pspc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Gain products are refreshed every cycle; each reflects the configuration and
    // core state as they stood in the cycle before.
    pspc_gain_mult u_gain_mult (
        .aclk (aclk),
        .cfg  (cfg),
        .fb   (fb),
        .prod (prod)
    );

    pspc_tick_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tick_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (advance),
        .pulse   (in_pulse_reg),
        .cfg     (cfg),
        .prod    (prod),
        .fb      (fb),
        .res     (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.window_done, out_res_reg.duty_ticks,
                       out_res_reg.speed_count, out_res_reg.pwm_out};

    // A freshly updated duty always lies within one tick and the full period.
    `PSPC_ASSERT_IMP(a_duty_in_range, aclk, aresetn, m_tvalid && out_res_reg.window_done, (out_res_reg.duty_ticks != 16'd0) && (out_res_reg.duty_ticks <= cfg.period), "updated duty outside [1, period]")

    // Controller updates never fall on consecutive cycles; the registered products rely on it.
    `PSPC_ASSERT_NXT(a_update_spacing, aclk, aresetn, core_res.window_done, !core_res.window_done, "controller updated on consecutive cycles")

    // A waiting tick is kept while the result register is stalled.
    `PSPC_ASSERT_NXT(a_tick_held, aclk, aresetn, in_valid_reg && out_valid_reg && !m_tready, in_valid_reg && !advance || in_valid_reg, "pending tick dropped during stall")

endmodule
